FILE: sv/swm_pkg.sv
// Shared constants and types for the sliding window maximum filter.
// No dependencies; imported by every module of the block.

package swm_pkg;

  localparam int WIN_DEPTH = 64;
  localparam int SMP_W     = 32;
  localparam int WSZ_W     = 7;
  localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int EW_W      = (CNT_W > WSZ_W) ? CNT_W : WSZ_W;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [CNT_W-1:0]        fill_t;
  typedef logic [EW_W-1:0]         win_t;
  typedef logic [IDX_W-1:0]        idx_t;

  typedef struct packed {
    logic adv;
    logic restart;
  } cell_ctl_t;

endpackage

FILE: sv/sliding_window_maximum_core.sv
// Sliding window maximum: a chain of cells where cell n holds the maximum of the last n+1 samples.
// An accepted item's result appears on the output register in the next cycle.
// Throughput: one item per cycle while in_stall is low; each cell takes its left neighbour's maximum in the same edge.
// An output register separates the sides; input stalls only while a result waits and out_stall is high.
// Reset (synchronous, active low) clears fill count, output valid and sets window_size to 1.
// Depends on swm_pkg and swm_cell.

module sliding_window_maximum_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [swm_pkg::SMP_W-1:0] in_sample,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [swm_pkg::SMP_W-1:0] out_window_max,
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::WSZ_W-1:0]     cfg_wr_data
);
  import swm_pkg::*;

  logic [WSZ_W-1:0] wsz_r;
  fill_t            fill_r, fill_nxt, fill_base;
  logic             out_valid_r, out_valid_nxt;
  sample_t          out_max_r, out_max_nxt;
  win_t             wsz_ext, eff_win, eff_m1;
  idx_t             sel;
  logic             accept, emit;
  cell_ctl_t        ctl;
  sample_t          cell_max [WIN_DEPTH];
  sample_t          cell_nxt [WIN_DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign ctl      = '{adv: accept, restart: in_restart};

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      swm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .sample   (in_sample),
        .prev_max (in_sample),
        .max_r    (cell_max[i]),
        .max_nxt  (cell_nxt[i])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .sample   (in_sample),
        .prev_max (cell_max[i-1]),
        .max_r    (cell_max[i]),
        .max_nxt  (cell_nxt[i])
      );
    end
  end

  always_comb begin
    wsz_ext = EW_W'(wsz_r);
    if (wsz_ext == '0) begin
      eff_win = EW_W'(1);
    end else if (wsz_ext > EW_W'(WIN_DEPTH)) begin
      eff_win = EW_W'(WIN_DEPTH);
    end else begin
      eff_win = wsz_ext;
    end
    eff_m1 = eff_win - EW_W'(1);
    sel    = eff_m1[IDX_W-1:0];
  end

  always_comb begin
    fill_base = in_restart ? '0 : fill_r;
    fill_nxt  = fill_r;
    emit      = 1'b0;
    if (accept) begin
      if (fill_base == CNT_W'(WIN_DEPTH)) begin
        fill_nxt = fill_base;
      end else begin
        fill_nxt = fill_base + CNT_W'(1);
      end
      emit = EW_W'(fill_nxt) >= eff_win;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_max_nxt   = out_max_r;
    if (accept) begin
      out_valid_nxt = emit;
      out_max_nxt   = cell_nxt[sel];
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsz_r       <= WSZ_W'(1);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wsz_r <= cfg_wr_data;
      end
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_max_r <= out_max_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_max_r;

endmodule

FILE: sv/swm_cell.sv
// One cell of the running maximum chain: cell n holds the maximum of the last n+1 samples.
// Depends on swm_pkg.

module swm_cell (
  input  logic               clk,
  input  swm_pkg::cell_ctl_t ctl,
  input  swm_pkg::sample_t   sample,
  input  swm_pkg::sample_t   prev_max,
  output swm_pkg::sample_t   max_r,
  output swm_pkg::sample_t   max_nxt
);
  import swm_pkg::*;

  always_comb begin
    max_nxt = max_r;
    if (ctl.adv) begin
      if (ctl.restart || (sample > prev_max)) begin
        max_nxt = sample;
      end else begin
        max_nxt = prev_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    max_r <= max_nxt;
  end

endmodule

FILE: sv/swm_checker.sv
// Port-level checks for sliding_window_maximum_core, attached by bind.
// Depends on swm_pkg.

module swm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [swm_pkg::SMP_W-1:0] in_sample,
  input logic                          in_restart,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [swm_pkg::SMP_W-1:0] out_window_max,
  input logic                          cfg_wr_en,
  input logic [swm_pkg::WSZ_W-1:0]     cfg_wr_data
);
  import swm_pkg::*;

  logic [WSZ_W-1:0] wsz_r;
  logic             acc;
  logic             small_win;

  assign acc       = in_valid && !in_stall;
  assign small_win = wsz_r <= WSZ_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsz_r <= WSZ_W'(1);
    end else if (cfg_wr_en) begin
      wsz_r <= cfg_wr_data;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_max))
    else $error("result changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("item taken while result waits");

  a_unit_window: assert property (@(posedge clk) disable iff (!rst_n)
    acc && small_win |=> out_valid && out_window_max == $past(in_sample))
    else $error("unit window result is not the sample");

  a_restart_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_restart && !small_win |=> !out_valid)
    else $error("result after restart before window filled");

endmodule

bind sliding_window_maximum_core swm_checker u_swm_checker (.*);
